// ===== sv/itoa_pkg.sv =====
package itoa_pkg;

	localparam int WordW    = 32;
	localparam int DecDigits = 10;
	localparam int BcdW     = 4 * DecDigits;
	localparam int DdSteps  = 8;
	localparam int MaxChars = 34;
	localparam int HexDigits = 8;

	typedef enum logic [1:0] {
		KIND_DEC  = 2'd0,
		KIND_HEX  = 2'd1,
		KIND_BIN  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef logic [6:0] char_t;
	typedef logic [5:0] len_t;
	typedef logic [MaxChars-1:0][6:0] text_t;

	localparam char_t CH_0     = 7'h30;
	localparam char_t CH_1     = 7'h31;
	localparam char_t CH_MINUS = 7'h2d;
	localparam char_t CH_X     = 7'h78;
	localparam char_t CH_B     = 7'h62;
	localparam char_t CH_A     = 7'h41;

	localparam len_t HexLen  = 6'd10;
	localparam len_t BinMax  = 6'd32;
	localparam len_t PfxLen  = 6'd2;

	typedef struct packed {
		kind_t            kind;
		logic             neg;
		len_t             nbits;
		logic [WordW-1:0] word;
		logic [BcdW-1:0]  bcd;
		logic [WordW-1:0] bin;
	} conv_t;

	// eight shift-add-3 steps of binary to BCD conversion
	function automatic conv_t dd_steps(input conv_t c);
		conv_t r;
		logic [3:0] dg;
		r = c;
		for (int s = 0; s < DdSteps; s++) begin
			for (int d = 0; d < DecDigits; d++) begin
				dg = r.bcd[d*4 +: 4];
				if (dg >= 4'd5)
					r.bcd[d*4 +: 4] = dg + 4'd3;
			end
			{r.bcd, r.bin} = {r.bcd, r.bin} << 1;
		end
		return r;
	endfunction

endpackage

// ===== sv/itoa_dabble_pipe.sv =====
module itoa_dabble_pipe import itoa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  conv_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output conv_t out_data
);

	logic  v_s2, v_s3, v_s4, v_s5;
	conv_t d_s2, d_s3, d_s4, d_s5;
	logic  rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5 = !v_s5 || out_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;

	assign in_ready  = rdy_s2;
	assign out_valid = v_s5;
	assign out_data  = d_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) d_s2 <= dd_steps(in_data);
		if (rdy_s3) d_s3 <= dd_steps(d_s2);
		if (rdy_s4) d_s4 <= dd_steps(d_s3);
		if (rdy_s5) d_s5 <= dd_steps(d_s4);
	end

endmodule

// ===== sv/itoa_serializer.sv =====
module itoa_serializer import itoa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load_valid,
	output logic  load_ready,
	input  text_t load_text,
	input  len_t  load_len,
	output logic  char_valid,
	input  logic  char_stall,
	output char_t char_code,
	output logic  last
);

	text_t sh_q;
	len_t  rem_q;
	logic  done;
	logic  take;

	assign char_valid = (rem_q != '0);
	assign char_code  = sh_q[0];
	assign last       = (rem_q == len_t'(1));
	assign take       = char_valid && !char_stall;
	assign done       = !char_valid || (last && !char_stall);
	assign load_ready = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load_valid && done) begin
			rem_q <= load_len;
		end else if (take) begin
			rem_q <= rem_q - len_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && done) begin
			sh_q <= load_text;
		end else if (take) begin
			sh_q <= {7'b0, sh_q[MaxChars-1:1]};
		end
	end

endmodule

// ===== sv/integer_to_ascii_formatter.sv =====
// Integer to ASCII text formatter.
// Item channel: kind, value, bit_count qualified by item_valid; the block
// holds item_stall high while it cannot take a beat. Kind selects signed
// decimal, "0x" plus eight uppercase hex digits, or "0b" plus the low
// bit_count bits (saturated at 32). Kind 3 gives no characters.
// Char channel: one character per beat on char_code, last marks the final
// character of a number. A stalled beat holds its payload.
// Path: each item passes one magnitude/shift stage, four BCD conversion
// stages of 8 bits each and one text build stage, then the output shift
// register that holds its first character.
// Throughput: the pipeline takes an item every cycle while item_stall is low;
// the output register sends one character per cycle while char_stall is low,
// and an item's text has 1 to 11 characters for decimal, 10 for hex and 2 to
// 34 for binary; a kind 3 item is loaded there but sends no character.
// When char_stall is high the stages fill and item_stall rises once all are
// full; nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits and the pending character count.
module integer_to_ascii_formatter import itoa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         kind,
	input  logic signed [31:0] value,
	input  logic [5:0]         bit_count,
	output logic               char_valid,
	input  logic               char_stall,
	output logic [6:0]         char_code,
	output logic               last
);

	// stage 1: magnitude and binary alignment
	logic        v_s1;
	conv_t       d_s1;
	logic        rdy_s1;
	logic        dd_ready;
	logic [31:0] uval;
	len_t        nb;
	conv_t       c_in;

	assign rdy_s1     = !v_s1 || dd_ready;
	assign item_stall = !rdy_s1;
	assign uval       = value;

	always_comb begin
		nb = (bit_count > BinMax) ? BinMax : bit_count;
		c_in.kind  = kind_t'(kind);
		c_in.neg   = (kind_t'(kind) == KIND_DEC) && uval[31];
		c_in.nbits = nb;
		c_in.word  = (kind_t'(kind) == KIND_BIN) ? (uval << (BinMax - nb)) : uval;
		c_in.bcd   = '0;
		c_in.bin   = c_in.neg ? (~uval + 32'd1) : uval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) d_s1 <= c_in;
	end

	// stages 2..5: BCD conversion
	logic  dd_valid;
	logic  rdy_s6;
	conv_t dd_data;

	itoa_dabble_pipe u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (dd_ready),
		.in_data   (d_s1),
		.out_valid (dd_valid),
		.out_ready (rdy_s6),
		.out_data  (dd_data)
	);

	// stage 6: text build
	logic            v_s6;
	text_t           txt_s6;
	len_t            len_s6;
	logic            ser_ready;
	logic [3:0]      lead;
	logic            found;
	logic [BcdW-1:0] dsh;
	char_t           dch [DecDigits];
	char_t           hch [HexDigits];
	logic [3:0]      nib;
	text_t           txt;
	len_t            len;

	assign rdy_s6 = !v_s6 || ser_ready;

	always_comb begin
		lead  = 4'd9;
		found = 1'b0;
		for (int i = 0; i < DecDigits - 1; i++) begin
			if (!found && dd_data.bcd[BcdW-1-4*i -: 4] != 4'd0) begin
				lead  = 4'(i);
				found = 1'b1;
			end
		end
		dsh = dd_data.bcd << {lead, 2'b00};
		for (int p = 0; p < DecDigits; p++)
			dch[p] = CH_0 + char_t'(dsh[BcdW-1-4*p -: 4]);
		for (int h = 0; h < HexDigits; h++) begin
			nib = dd_data.word[WordW-1-4*h -: 4];
			hch[h] = (nib > 4'd9) ? (CH_A + char_t'(nib - 4'd10)) : (CH_0 + char_t'(nib));
		end

		txt = '0;
		len = '0;
		case (dd_data.kind)
			KIND_DEC: begin
				if (dd_data.neg) begin
					txt[0] = CH_MINUS;
					for (int p = 0; p < DecDigits; p++)
						txt[p+1] = dch[p];
				end else begin
					for (int p = 0; p < DecDigits; p++)
						txt[p] = dch[p];
				end
				len = len_t'(4'd10 - lead) + len_t'(dd_data.neg);
			end
			KIND_HEX: begin
				txt[0] = CH_0;
				txt[1] = CH_X;
				for (int h = 0; h < HexDigits; h++)
					txt[h+2] = hch[h];
				len = HexLen;
			end
			KIND_BIN: begin
				txt[0] = CH_0;
				txt[1] = CH_B;
				for (int b = 0; b < WordW; b++)
					txt[b+2] = dd_data.word[WordW-1-b] ? CH_1 : CH_0;
				len = dd_data.nbits + PfxLen;
			end
			default: begin
				len = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= dd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			txt_s6 <= txt;
			len_s6 <= len;
		end
	end

	// output shift register
	itoa_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v_s6),
		.load_ready (ser_ready),
		.load_text  (txt_s6),
		.load_len   (len_s6),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.last       (last)
	);

endmodule
